/* rtl/core/ntr_pkg.sv */
package ntr_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(MAX_INPUTS);
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);
    // floor(S * TABLE_DEPTH / 2^28) is an arithmetic shift of S by this much
    localparam int TSHIFT      = 28 - TIDX_W;

    localparam logic [1:0] ACT_SIGMOID = 2'd0;
    localparam logic [1:0] ACT_RELU    = 2'd1;
    localparam logic [1:0] ACT_TANH    = 2'd2;

    localparam logic [1:0] REG_ACT_KIND = 2'd0;
    localparam logic [1:0] REG_LRATE    = 2'd1;
    localparam logic [1:0] REG_VLEN     = 2'd2;

    localparam logic       OP_FORWARD = 1'b0;
    localparam logic       OP_UPDATE  = 1'b1;

    typedef logic signed [15:0] act_table_t [TABLE_DEPTH];

    // Shift-subtract long division, used only while building the tables.
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] round_ratio(input logic [63:0] num, input logic [63:0] den);
        return udiv(num * 64'd8192 + den, den << 1);
    endfunction

    // Builds the sigmoid or tanh table from powers of exp(-16/TABLE_DEPTH) in Q2.30, rounded at each step.
    function automatic act_table_t build_table(input logic is_tanh);
        act_table_t  tab;
        logic [63:0] pw [TABLE_DEPTH+1];
        logic [63:0] h;
        logic [63:0] e;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] one;
        logic [63:0] t;
        logic [63:0] sg;
        int          m;
        int          k;
        one  = 64'd1 << 30;
        h    = (64'd16 << 30) / TABLE_DEPTH;
        e    = one;
        term = one;
        for (int n = 1; n <= 30; n++) begin
            term = udiv((term * h) >> 30, 64'(n));
            e    = e + term;
        end
        r = udiv((64'd1 << 60) + (e >> 1), e);
        pw[0] = one;
        for (int n = 1; n <= TABLE_DEPTH; n++) begin
            pw[n] = (pw[n-1] * r + (64'd1 << 29)) >> 30;
        end
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            m  = n - TABLE_DEPTH / 2;
            k  = (m < 0) ? -m : m;
            t  = round_ratio(one - pw[2*k], one + pw[2*k]);
            sg = round_ratio((m < 0) ? pw[k] : one, one + pw[k]);
            if (is_tanh) begin
                tab[n] = (m < 0) ? -16'(t) : 16'(t);
            end else begin
                tab[n] = 16'(sg);
            end
        end
        return tab;
    endfunction

    localparam act_table_t SIGMOID_TABLE = build_table(1'b0);
    localparam act_table_t TANH_TABLE    = build_table(1'b1);

endpackage

/* rtl/core/ntr_weight_mem.sv */
module ntr_weight_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          we,
    input  logic [ntr_pkg::ADDR_W-1:0]    waddr,
    input  logic signed [15:0]            wdata,
    input  logic [ntr_pkg::ADDR_W-1:0]    raddr,
    output logic signed [15:0]            rdata
);

    logic signed [15:0]                mem [ntr_pkg::MAX_INPUTS];
    logic [ntr_pkg::MAX_INPUTS-1:0]    valid_reg;
    logic signed [15:0]                rdata_reg;

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : 16'sd0;
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ntr_activate.sv */
module ntr_activate (
    input  logic signed [40:0] pre_sum,
    input  logic [1:0]         act_kind,
    output logic signed [15:0] act
);

    logic signed [40:0]                 rnd;
    logic signed [28:0]                 relu_q;
    logic signed [15:0]                 relu_v;
    logic signed [21:0]                 tidx;
    logic [ntr_pkg::TIDX_W-1:0]         tsel;

    always_comb begin
        rnd    = (pre_sum + 41'sd2048) >>> 12;
        relu_q = rnd[28:0];
        if (relu_q > 29'sd32767) begin
            relu_v = 16'sd32767;
        end else if (relu_q < 29'sd0) begin
            relu_v = 16'sd0;
        end else begin
            relu_v = relu_q[15:0];
        end

        tidx = 22'(pre_sum >>> ntr_pkg::TSHIFT) + 22'(ntr_pkg::TABLE_DEPTH / 2);
        if (tidx < 22'sd0) begin
            tsel = '0;
        end else if (tidx > 22'(ntr_pkg::TABLE_DEPTH - 1)) begin
            tsel = '1;
        end else begin
            tsel = tidx[ntr_pkg::TIDX_W-1:0];
        end

        unique case (act_kind)
            ntr_pkg::ACT_SIGMOID: act = ntr_pkg::SIGMOID_TABLE[tsel];
            ntr_pkg::ACT_RELU:    act = relu_v;
            ntr_pkg::ACT_TANH:    act = ntr_pkg::TANH_TABLE[tsel];
            default:              act = 16'sd0;
        endcase
    end

endmodule

/* rtl/core/neuron_mac_activate_train_top.sv */
// Each item is taken in ST_IDLE (weight memory read), then passes ST_MUL (multiply)
// and ST_ACC (accumulate or write-back); s_tready is low until it is back in ST_IDLE.
// A last item then loads the output register in ST_ACT and gives its result on m_tvalid,
// waiting in ST_ACT while the previous result still waits in the output register.
// Reset (aresetn low, synchronous): clears weights (per-entry valid bits), bias,
// accumulator, element count and result valid; configuration registers return to their defaults.
module neuron_mac_activate_train_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample, [31:16] error_term
    input  logic        s_tuser,   // [0] op
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] activation
    output logic [1:0]  m_tuser    // [0] kind, [1] length_error
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_ACT} state_t;

    state_t             state_reg;
    logic [1:0]         kind_cfg_reg;
    logic [15:0]        lrate_reg;
    logic [6:0]         vlen_reg;

    logic signed [39:0] acc_reg;
    logic [6:0]         index_reg;
    logic signed [15:0] bias_reg;

    // item payload held while it is worked on
    logic               op_reg;
    logic               last_reg;
    logic signed [15:0] x_reg;
    logic [6:0]         pos_reg;
    logic               hw_reg;
    logic signed [32:0] step_reg;
    logic signed [31:0] prod_reg;
    logic signed [48:0] stepx_reg;
    logic signed [15:0] w_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_act_reg;
    logic               m_kind_reg;
    logic               m_err_reg;

    logic               accept;
    logic signed [15:0] rd_w;
    logic signed [32:0] step_next;
    logic signed [40:0] acc_sum;
    logic signed [39:0] acc_next;
    logic signed [48:0] wstep;
    logic signed [22:0] w_diff;
    logic signed [15:0] w_next;
    logic signed [32:0] bstep;
    logic signed [17:0] b_diff;
    logic signed [15:0] bias_next;
    logic signed [40:0] pre_sum;
    logic signed [15:0] act;
    logic               len_err;
    logic               out_free;
    logic               mem_we;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign step_next = $signed({1'b0, lrate_reg}) * $signed(s_tdata[31:16]);

    always_comb begin
        // accumulate with saturation to 40 bits
        acc_sum = {acc_reg[39], acc_reg} + {{9{prod_reg[31]}}, prod_reg};
        if (acc_sum[40] != acc_sum[39]) begin
            acc_next = acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
            acc_next = acc_sum[39:0];
        end

        // weight step: round to nearest, ties up, then saturate
        wstep  = (stepx_reg + 49'sd134217728) >>> 28;
        w_diff = {{7{w_reg[15]}}, w_reg} - wstep[22:0];
        if (w_diff > 23'sd32767) begin
            w_next = 16'sd32767;
        end else if (w_diff < -23'sd32768) begin
            w_next = -16'sd32768;
        end else begin
            w_next = w_diff[15:0];
        end

        bstep  = (step_reg + 33'sd32768) >>> 16;
        b_diff = {{2{bias_reg[15]}}, bias_reg} - bstep[17:0];
        if (b_diff > 18'sd32767) begin
            bias_next = 16'sd32767;
        end else if (b_diff < -18'sd32768) begin
            bias_next = -16'sd32768;
        end else begin
            bias_next = b_diff[15:0];
        end

        pre_sum = {acc_reg[39], acc_reg} + {{13{bias_reg[15]}}, bias_reg, 12'd0};
        len_err = ({1'b0, pos_reg} + 8'd1 != {1'b0, vlen_reg})
               || (vlen_reg > 7'(ntr_pkg::MAX_INPUTS));
    end

    assign mem_we = (state_reg == ST_ACC) && (op_reg == ntr_pkg::OP_UPDATE) && hw_reg;

    ntr_weight_mem u_wmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (pos_reg[ntr_pkg::ADDR_W-1:0]),
        .wdata   (w_next),
        .raddr   (index_reg[ntr_pkg::ADDR_W-1:0]),
        .rdata   (rd_w)
    );

    ntr_activate u_act (
        .pre_sum  (pre_sum),
        .act_kind (kind_cfg_reg),
        .act      (act)
    );

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser;
            last_reg <= s_tlast;
            x_reg    <= s_tdata[15:0];
            pos_reg  <= index_reg;
            hw_reg   <= (index_reg < vlen_reg) && (index_reg < 7'(ntr_pkg::MAX_INPUTS));
            step_reg <= step_next;
        end
        if (state_reg == ST_MUL) begin
            w_reg     <= rd_w;
            prod_reg  <= x_reg * rd_w;
            stepx_reg <= step_reg * x_reg;
        end
        if (state_reg == ST_ACT && out_free) begin
            m_act_reg  <= (op_reg == ntr_pkg::OP_FORWARD && !len_err) ? act : 16'sd0;
            m_kind_reg <= op_reg;
            m_err_reg  <= len_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_cfg_reg <= ntr_pkg::ACT_SIGMOID;
            lrate_reg    <= 16'd655;
            vlen_reg     <= 7'd64;
            acc_reg      <= '0;
            index_reg    <= '0;
            bias_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    ntr_pkg::REG_ACT_KIND: kind_cfg_reg <= cfg_wdata[1:0];
                    ntr_pkg::REG_LRATE:    lrate_reg    <= cfg_wdata;
                    ntr_pkg::REG_VLEN:     vlen_reg     <= cfg_wdata[6:0];
                    default:               ;
                endcase
            end
            // drop the result once taken; a last item reloads it in ST_ACT
            if (m_valid_reg && m_tready && state_reg != ST_ACT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    // the weight read at index_reg issues on this edge
                    if (accept) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (op_reg == ntr_pkg::OP_FORWARD && hw_reg) begin
                        acc_reg <= acc_next;
                    end
                    if (index_reg != 7'd127) begin
                        index_reg <= index_reg + 7'd1;
                    end
                    state_reg <= last_reg ? ST_ACT : ST_IDLE;
                end
                ST_ACT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        if (op_reg == ntr_pkg::OP_UPDATE && !len_err) begin
                            bias_reg <= bias_next;
                        end
                        acc_reg     <= '0;
                        index_reg   <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_act_reg;
    assign m_tuser  = {m_err_reg, m_kind_reg};

endmodule

/* rtl/core/ntr_checker.sv */
module ntr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_zero_act: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata == 16'd0)
        else $error("update or error result carries an activation");

    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after an item");

endmodule

bind neuron_mac_activate_train_top ntr_checker u_ntr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
